### hw/rtl/u16u8_pkg.sv
// Shared types, constants and UTF-8 byte helpers for the UTF-16LE to UTF-8 transcoder.
package u16u8_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [5:0]  HIGH_SURR_HI = 6'b110110;
  localparam logic [5:0]  LOW_SURR_HI  = 6'b110111;

  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  // One decoded request for the byte emitter: an optional U+FFFD ahead of
  // an optional code point.
  typedef struct packed {
    logic        pre_repl;
    logic        cp_valid;
    logic [20:0] cp;
  } u16u8_cmd_t;

  // Sequence length minus one.
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] len;
    if (cp <= 21'h00007F) begin
      len = LEN_1;
    end else if (cp <= 21'h0007FF) begin
      len = LEN_2;
    end else if (cp <= 21'h00FFFF) begin
      len = LEN_3;
    end else begin
      len = LEN_4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] grp;
    grp = len_m1 - idx;
    if (idx == 2'd0) begin
      case (len_m1)
        LEN_1:   b = {1'b0, cp[6:0]};
        LEN_2:   b = {3'b110, cp[10:6]};
        LEN_3:   b = {4'b1110, cp[15:12]};
        LEN_4:   b = {5'b11110, cp[20:18]};
        default: b = 8'h00;
      endcase
    end else begin
      case (grp)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        2'd2:    b = {2'b10, cp[17:12]};
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

### hw/rtl/u16u8_if.sv
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

### hw/rtl/u16u8_front.sv
// Front end: accepts code units, tracks surrogate and end-of-string state, builds requests.
module u16u8_front (
  input  logic                 clk,
  input  logic                 rst,
  u16u8_unit_if.sink           unit_ch,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output u16u8_pkg::u16u8_cmd_t cmd
);
  import u16u8_pkg::*;

  logic       high_pending, high_pending_next;
  logic [9:0] high_bits, high_bits_next;
  logic       string_ended, string_ended_next;
  logic       accept;
  logic       is_high, is_low;
  logic [15:0] w;

  assign w       = unit_ch.code_unit;
  assign is_high = (w[15:10] == HIGH_SURR_HI);
  assign is_low  = (w[15:10] == LOW_SURR_HI);

  assign unit_ch.ready = cmd_ready;
  assign accept        = unit_ch.valid && unit_ch.ready;

  always_comb begin
    logic consumed;
    consumed          = 1'b0;
    cmd               = '0;
    high_pending_next = high_pending;
    high_bits_next    = high_bits;
    string_ended_next = string_ended;
    if (!string_ended) begin
      if (high_pending) begin
        high_pending_next = 1'b0;
        high_bits_next    = '0;
        if (is_low) begin
          cmd.cp_valid = 1'b1;
          cmd.cp       = SUPP_BASE + {1'b0, high_bits, w[9:0]};
          consumed     = 1'b1;
        end else begin
          cmd.pre_repl = 1'b1;
        end
      end
      if (!consumed) begin
        if (w == 16'h0000) begin
          string_ended_next = 1'b1;
        end else if (is_high) begin
          if (unit_ch.last_unit) begin
            cmd.cp_valid = 1'b1;
            cmd.cp       = {5'd0, REPL_CHAR};
          end else begin
            high_pending_next = 1'b1;
            high_bits_next    = w[9:0];
          end
        end else if (is_low) begin
          cmd.cp_valid = 1'b1;
          cmd.cp       = {5'd0, REPL_CHAR};
        end else begin
          cmd.cp_valid = 1'b1;
          cmd.cp       = {5'd0, w};
        end
      end
    end
    if (unit_ch.last_unit) begin
      high_pending_next = 1'b0;
      high_bits_next    = '0;
      string_ended_next = 1'b0;
    end
  end

  // Units that produce no bytes are absorbed without a queue entry.
  assign cmd_valid = accept && (cmd.pre_repl || cmd.cp_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
      high_bits    <= '0;
      string_ended <= 1'b0;
    end else if (accept) begin
      high_pending <= high_pending_next;
      high_bits    <= high_bits_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

### hw/rtl/u16u8_queue.sv
// Small request queue decoupling the front end from the byte emitter.
module u16u8_queue #(
  parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  u16u8_pkg::u16u8_cmd_t wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output u16u8_pkg::u16u8_cmd_t rd_data
);
  import u16u8_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u16u8_cmd_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hw/rtl/u16u8_back.sv
// Byte emitter: each request goes out as UTF-8 bytes, registered, one per cycle unless stalled.
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  u16u8_pkg::u16u8_cmd_t cmd,
  u16u8_byte_if.source          byte_ch
);
  import u16u8_pkg::*;

  logic        busy;
  logic        repl_pend;
  logic        cp_valid;
  logic [20:0] cp;
  logic [1:0]  idx;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        run_last;

  logic [20:0] cur_cp;
  logic [1:0]  len_m1;
  logic        cp_done, req_done, advance, load;

  assign cur_cp   = repl_pend ? {5'd0, REPL_CHAR} : cp;
  assign len_m1   = utf8_len_m1(cur_cp);
  assign cp_done  = (idx == len_m1);
  // Last byte of the request: the replacement byte run is last only if nothing follows it.
  assign req_done = cp_done && !(repl_pend && cp_valid);
  assign advance  = busy && (!out_valid || byte_ch.ready);
  assign load     = cmd_valid && (!busy || (advance && req_done));
  assign cmd_ready = !busy || (advance && req_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      repl_pend <= 1'b0;
      cp_valid  <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (byte_ch.ready) begin
        out_valid <= 1'b0;
      end
      // A new request only loads once the current one has emitted its last byte.
      if (load) begin
        busy      <= 1'b1;
        repl_pend <= cmd.pre_repl;
        cp_valid  <= cmd.cp_valid;
        idx       <= '0;
      end else if (advance) begin
        if (cp_done) begin
          idx <= '0;
          if (repl_pend && cp_valid) begin
            repl_pend <= 1'b0;
          end else begin
            busy <= 1'b0;
          end
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp <= cmd.cp;
    end
    if (advance) begin
      out_byte <= utf8_byte(cur_cp, len_m1, idx);
      run_last <= req_done;
    end
  end

  assign byte_ch.valid    = out_valid;
  assign byte_ch.out_byte = out_byte;
  assign byte_ch.run_last = run_last;

endmodule

### hw/rtl/utf16le_to_utf8_transcoder.sv
// Top level of the UTF-16LE to UTF-8 transcoder: front end, request queue, byte emitter.
// A unit's request passes the queue and the emitter registers, then the output register.
// Throughput: one output byte per cycle from the emitter while the output is not stalled;
//   a unit yields 1 to 6 bytes (3 for common BMP text) or none.
// The front end accepts a unit every cycle while the request queue has room.
// Reset (rst, synchronous, active high) clears surrogate and end-of-string state,
//   empties the queue and drops any byte waiting at the output.
module utf16le_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  u16u8_unit_if.sink   unit_ch,
  u16u8_byte_if.source byte_ch
);
  import u16u8_pkg::*;

  // Request from the front end into the queue.
  u16u8_cmd_t fe_cmd;
  logic       fe_valid;
  logic       fe_ready;

  // Request from the queue into the emitter.
  u16u8_cmd_t be_cmd;
  logic       be_valid;
  logic       be_ready;

  // Classifies each unit, pairs surrogates and tracks the string end.
  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .unit_ch   (unit_ch),
    .cmd_valid (fe_valid),
    .cmd_ready (fe_ready),
    .cmd       (fe_cmd)
  );

  // Lets the front end keep taking units while a multi-byte sequence drains.
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_cmd),
    .rd_valid (be_valid),
    .rd_ready (be_ready),
    .rd_data  (be_cmd)
  );

  // Walks each request byte by byte into the registered output.
  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (be_valid),
    .cmd_ready (be_ready),
    .cmd       (be_cmd),
    .byte_ch   (byte_ch)
  );

endmodule

### hw/rtl/u16u8_checker.sv
// Port-level checks on the transcoder output, bound to the top level.
module u16u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last
);

  // A stalled byte holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("output byte changed while stalled");

  // Reset leaves nothing at the output.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A request never ends on a lead byte.
  a_last_not_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_last |-> out_byte[7:6] != 2'b11)
    else $error("request ends on a lead byte");

  // Never a NUL, an overlong lead or a lead beyond U+10FFFF.
  a_legal_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte != 8'h00 && out_byte[7:1] != 7'b1100000
                  && out_byte[7:3] != 5'b11111
                  && !(out_byte[7:3] == 5'b11110 && out_byte[2:0] > 3'd4))
    else $error("illegal UTF-8 byte");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (byte_ch.valid),
  .out_ready (byte_ch.ready),
  .out_byte  (byte_ch.out_byte),
  .run_last  (byte_ch.run_last)
);

### test/utf16le_to_utf8_transcoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-16LE to UTF-8 transcoder: directed table, then random strings.
module utf16le_to_utf8_transcoder_tb;

  // Code unit ranges for the two surrogate halves.
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  localparam int RANDOM_UNITS   = 334;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MAX_PRINTED    = 40;

  // One row of the directed table. When typed is set, the bytes are written out
  // here (first byte in the top octet); otherwise the predictor supplies them.
  typedef struct packed {
    logic [15:0] cu;
    logic        fin;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] bytes;
  } dir_row_t;

  // One expected output byte with its end-of-run mark.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
  } utf8_byte_t;

  // Mix of code point classes used to build random strings.
  typedef enum logic [2:0] {
    K_ASCII, K_TWO, K_THREE, K_PAIR, K_LONE_HIGH, K_LONE_LOW, K_ZERO, K_ANY
  } unit_kind_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    '{16'h0041, 1'b0, 1'b1, 3'd1, 48'h41_00_00_00_00_00},   // plain ASCII right after reset
    '{16'h0001, 1'b0, 1'b1, 3'd1, 48'h01_00_00_00_00_00},   // smallest non-zero unit
    '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},   // top of one-byte range
    '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},   // bottom of two-byte range
    '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},   // top of two-byte range
    '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},   // bottom of three-byte range
    '{16'hD7FF, 1'b0, 1'b0, 3'd0, 48'h0},                   // just under the surrogates
    '{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0},                   // just over the surrogates
    '{16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},   // largest unit
    '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00},   // lone low surrogate
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},                   // high held, nothing out
    '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},   // lowest supplementary
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
    '{16'hDFFF, 1'b0, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},   // highest supplementary
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
    '{16'h0041, 1'b0, 1'b1, 3'd4, 48'hEF_BF_BD_41_00_00},   // held high broken by ASCII
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
    '{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0},                   // broken pair, six bytes
    '{16'hD801, 1'b0, 1'b1, 3'd0, 48'h0},
    '{16'hD802, 1'b0, 1'b0, 3'd0, 48'h0},                   // high after high
    '{16'h0000, 1'b0, 1'b0, 3'd0, 48'h0},                   // zero flushes held high, ends
    '{16'h1234, 1'b0, 1'b1, 3'd0, 48'h0},                   // silent after end of string
    '{16'hDC00, 1'b1, 1'b1, 3'd0, 48'h0},                   // silent, last flag clears
    '{16'hDABC, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00},   // high surrogate as last unit
    '{16'h0000, 1'b1, 1'b1, 3'd0, 48'h0},                   // zero that is also last
    '{16'hFFFE, 1'b1, 1'b0, 3'd0, 48'h0}
  };

  logic clk = 1'b0;
  logic rst;

  u16u8_unit_if unit_ch();
  u16u8_byte_if byte_ch();

  utf16le_to_utf8_transcoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .unit_ch (unit_ch),
    .byte_ch (byte_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state, mirrors the transcoder's surrogate and end-of-string state.
  logic       held_high;
  logic [9:0] held_bits;
  logic       str_ended;

  logic [7:0]  step_bytes[$];     // bytes the last accepted unit produces
  logic [2:0]  model_n;
  logic [47:0] model_bytes;

  utf8_byte_t utf8_expected[$];   // bytes still to come out, oldest first
  int         mismatches;
  int         burst_left;
  logic       steady;             // sender runs with no gaps while set

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_step_byte(input logic [7:0] b);
    step_bytes = {step_bytes, b};
  endtask

  task automatic append_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_step_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      add_step_byte({3'b110, cp[10:6]});
      add_step_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      add_step_byte({4'b1110, cp[15:12]});
      add_step_byte({2'b10, cp[11:6]});
      add_step_byte({2'b10, cp[5:0]});
    end else begin
      add_step_byte({5'b11110, cp[20:18]});
      add_step_byte({2'b10, cp[17:12]});
      add_step_byte({2'b10, cp[11:6]});
      add_step_byte({2'b10, cp[5:0]});
    end
  endtask

  // Work out the bytes one code unit yields and advance the state.
  task automatic transcode_unit(input logic [15:0] cu, input logic fin);
    logic is_hi;
    logic is_lo;
    logic paired;
    is_hi  = (cu >= HIGH_FIRST) && (cu <= HIGH_LAST);
    is_lo  = (cu >= LOW_FIRST) && (cu <= LOW_LAST);
    paired = 1'b0;
    step_bytes.delete();
    if (!str_ended) begin
      if (held_high) begin
        held_high = 1'b0;
        if (is_lo) begin
          append_code_point(u16u8_pkg::SUPP_BASE + {1'b0, held_bits, cu[9:0]});
          paired = 1'b1;
        end else begin
          append_code_point({5'd0, u16u8_pkg::REPL_CHAR});
        end
        held_bits = '0;
      end
      if (!paired) begin
        if (cu == 16'h0000) begin
          str_ended = 1'b1;
        end else if (is_hi) begin
          if (fin) begin
            append_code_point({5'd0, u16u8_pkg::REPL_CHAR});
          end else begin
            held_high = 1'b1;
            held_bits = cu[9:0];
          end
        end else if (is_lo) begin
          append_code_point({5'd0, u16u8_pkg::REPL_CHAR});
        end else begin
          append_code_point({5'd0, cu});
        end
      end
    end
    if (fin) begin
      held_high = 1'b0;
      held_bits = '0;
      str_ended = 1'b0;
    end
    model_n     = 3'(step_bytes.size());
    model_bytes = '0;
    for (int k = 0; k < step_bytes.size(); k++)
      model_bytes[47 - 8*k -: 8] = step_bytes[k];
  endtask

  task automatic queue_bytes(input logic [2:0] n, input logic [47:0] bytes);
    utf8_byte_t e;
    for (int k = 0; k < n; k++) begin
      e.data     = bytes[47 - 8*k -: 8];
      e.run_last = (k == n - 1);
      utf8_expected = {utf8_expected, e};
    end
  endtask

  // Hand one unit to the block. Between bursts valid drops for a random gap (none while steady
  // is set); inside a burst the next unit follows on the next falling edge.
  task automatic send_unit(input logic [15:0] cu, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 6);
      for (int g = 0; g < gap; g++) begin
        @(negedge clk);
        unit_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    unit_ch.valid     = 1'b1;
    unit_ch.code_unit = cu;
    unit_ch.last_unit = fin;
    do @(posedge clk); while (!(unit_ch.valid && unit_ch.ready));
    burst_left--;
    transcode_unit(cu, fin);
  endtask

  // Hold off new requests until every expected byte has come out or the drain limit runs out.
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    @(negedge clk);
    unit_ch.valid = 1'b0;
    burst_left = 0;
    while (utf8_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic [15:0] pick_unit(input unit_kind_t kind);
    logic [15:0] cu;
    case (kind)
      K_ASCII:     cu = 16'($urandom_range(16'h0001, 16'h007F));
      K_TWO:       cu = 16'($urandom_range(16'h0080, 16'h07FF));
      K_THREE:     cu = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                             : 16'($urandom_range(16'hE000, 16'hFFFF));
      K_LONE_HIGH: cu = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
      K_LONE_LOW:  cu = 16'($urandom_range(LOW_FIRST, LOW_LAST));
      K_ZERO:      cu = 16'h0000;
      default:     cu = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return cu;
  endfunction

  // Output side: every accepted byte is held against the oldest expectation.
  always @(posedge clk) begin
    utf8_byte_t e;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (utf8_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h run_last %0b",
                                  byte_ch.out_byte, byte_ch.run_last));
      end else begin
        e = utf8_expected.pop_front();
        if (byte_ch.out_byte !== e.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", byte_ch.out_byte, e.data));
        if (byte_ch.run_last !== e.run_last)
          report_mismatch($sformatf("run_last %0b, want %0b on byte %02h",
                                    byte_ch.run_last, e.run_last, e.data));
      end
    end
  end

  // Receiver: the stall pattern rotates through four patterns, one of which never stalls.
  initial begin
    int cyc;
    cyc = 0;
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      case ((cyc / 50) % 4)
        0:       byte_ch.ready = 1'b1;
        1:       byte_ch.ready = 1'($urandom_range(0, 1));
        2:       byte_ch.ready = (cyc % 4 == 0);
        default: byte_ch.ready = ($urandom_range(0, 3) != 0);
      endcase
      cyc++;
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [15:0] str_units[$];
    int          counted;
    int          n_cp;
    int          r;
    logic        fin_at_end;
    logic        mid_drain_done;
    unit_kind_t  kind;

    held_high  = 1'b0;
    held_bits  = '0;
    str_ended  = 1'b0;
    mismatches = 0;
    burst_left = 0;
    steady     = 1'b0;
    counted    = 0;
    mid_drain_done = 1'b0;

    rst               = 1'b1;
    unit_ch.valid     = 1'b0;
    unit_ch.code_unit = '0;
    unit_ch.last_unit = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: ranges, surrogate pairing and the end-of-string rules.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_unit(DIRECTED[i].cu, DIRECTED[i].fin);
      if (DIRECTED[i].typed)
        queue_bytes(DIRECTED[i].n, DIRECTED[i].bytes);
      else
        queue_bytes(model_n, model_bytes);
    end
    wait_for_drain();

    // Random strings: mostly well-formed text, some broken surrogates, zeros
    // and arbitrary units; a few strings run on without a last flag.
    while (counted < RANDOM_UNITS) begin
      str_units.delete();
      n_cp = $urandom_range(1, 8);
      for (int c = 0; c < n_cp; c++) begin
        r = $urandom_range(0, 99);
        if (r < 25)      kind = K_ASCII;
        else if (r < 40) kind = K_TWO;
        else if (r < 60) kind = K_THREE;
        else if (r < 82) kind = K_PAIR;
        else if (r < 88) kind = K_LONE_HIGH;
        else if (r < 93) kind = K_LONE_LOW;
        else if (r < 96) kind = K_ZERO;
        else             kind = K_ANY;
        if (kind == K_PAIR) begin
          str_units = {str_units, pick_unit(K_LONE_HIGH)};
          str_units = {str_units, pick_unit(K_LONE_LOW)};
        end else begin
          str_units = {str_units, pick_unit(kind)};
        end
      end
      fin_at_end = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 3) == 0)
        steady = ~steady;
      foreach (str_units[u]) begin
        send_unit(str_units[u], fin_at_end && (u == str_units.size() - 1));
        queue_bytes(model_n, model_bytes);
        counted++;
      end
      if (!mid_drain_done && counted >= RANDOM_UNITS / 2) begin
        wait_for_drain();
        mid_drain_done = 1'b1;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (utf8_expected.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", utf8_expected.size()));

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
